### src/bhc_pkg.sv
`default_nettype none

package bhc_pkg;

   localparam int BHC_MAX_BOUNDS = 7;
   localparam int BHC_REG_BOUNDS = 7;

   localparam logic ACT_OBSERVE  = 1'b0;
   localparam logic ACT_SNAPSHOT = 1'b1;

   localparam logic [2:0] CSR_ACTIVE_BOUNDS = 3'd0;
   localparam logic [2:0] CSR_BOUND_FIRST   = 3'd1;

   localparam logic [2:0] ACTIVE_BOUNDS_RESET = 3'd1;

   typedef struct packed {
      logic        action;
      logic [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  bucket_id;
      logic [31:0] bucket_total;
      logic [31:0] samples_seen;
      logic [63:0] sample_total;
      logic        last_bucket;
   } rsp_type;

   // sample moving down the cell row
   typedef struct packed {
      logic        valid;
      logic        placed;
      logic [31:0] sample;
   } tok_type;

   typedef struct packed {
      logic active;
      logic is_over;
      logic snap_load;
      logic snap_shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### src/bhc_cell.sv
`default_nettype none

module bhc_cell
   import bhc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tok_type       prev_tok,
   input  wire logic [31:0]   bound,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [31:0]   snap_from_next,
   output tok_type            next_tok,
   output logic [31:0]        snap_to_prev
);

   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] snap_ff, snap_in;
   tok_type     tok_ff, tok_in;
   logic        hit;

   // claim the sample if no earlier cell took it
   assign hit = prev_tok.valid && !prev_tok.placed &&
                (ctrl.is_over || (ctrl.active && (bound >= prev_tok.sample)));

   always_comb begin
      cnt_in = hit ? cnt_ff + 32'd1 : cnt_ff;
      tok_in = prev_tok;
      tok_in.placed = prev_tok.placed | hit;
      if (ctrl.snap_load) begin
         snap_in = cnt_ff;
      end else if (ctrl.snap_shift) begin
         snap_in = snap_from_next;
      end else begin
         snap_in = snap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.placed <= tok_in.placed;
      tok_ff.sample <= tok_in.sample;
      snap_ff       <= snap_in;
   end

   assign next_tok     = tok_ff;
   assign snap_to_prev = snap_ff;

endmodule

`default_nettype wire

### src/bucketed_histogram_counter_top.sv
// Bucketed histogram counter.
// Requests arrive on req_ (valid/stall) carrying an action and a sample.
// An observe request enters a row of MAX_BOUNDS+1 cells; the sample moves
// one cell per cycle and the first active cell whose bound is at least the
// sample (or the overflow cell, index min(active_bounds, MAX_BOUNDS)) bumps
// its counter. Observe requests are taken one per cycle while no snapshot is
// in progress and give no response. A snapshot request stalls the request
// side, waits until the row has drained, copies every counter into the
// snapshot chain and shifts it out on rsp_, one response per cycle, bucket
// 0 first; the overflow bucket's response has last_bucket set.
// A stalled response holds rsp_data and pauses the shift; new requests
// are taken again once the last response is loaded.
// csr_ writes (index, data) are always ready and must occur while idle.
// Synchronous reset clears counters, sum, count, bounds and sets
// active_bounds to 1.
`default_nettype none

module bucketed_histogram_counter_top
   import bhc_pkg::*;
#(
   parameter int MAX_BOUNDS = BHC_MAX_BOUNDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int CELLS = MAX_BOUNDS + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   // configuration
   logic [2:0]  active_ff;
   logic [31:0] bounds_ff [BHC_REG_BOUNDS];
   logic [2:0]  n_used;

   // control
   logic [1:0]  state_ff, state_in;
   logic [2:0]  rd_ff, rd_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] sum_ff, sum_in;
   tok_type     tok_head_ff, tok_head_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_accept;
   logic        busy;
   logic        snap_load;
   logic        rsp_load;
   logic        rsp_is_last;

   tok_type     chain_tok [CELLS + 1];
   logic [31:0] snap_link [CELLS + 1];

   assign csr_ready = 1'b1;

   // hold out-of-range settings at the largest row the block has
   assign n_used = (active_ff > 3'(MAX_BOUNDS)) ? 3'(MAX_BOUNDS) : active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_BOUNDS_RESET;
         for (int k = 0; k < BHC_REG_BOUNDS; k++) begin
            bounds_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ACTIVE_BOUNDS) begin
            active_ff <= csr_data[2:0];
         end else begin
            bounds_ff[csr_index - CSR_BOUND_FIRST] <= csr_data;
         end
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // any sample still travelling down the row
   always_comb begin
      busy = 1'b0;
      for (int k = 0; k <= CELLS; k++) begin
         busy = busy | chain_tok[k].valid;
      end
   end

   assign snap_load   = (state_ff == ST_DRAIN) && !busy;
   assign rsp_load    = (state_ff == ST_SHIFT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_is_last = (rd_ff == n_used);

   always_comb begin
      state_in    = state_ff;
      rd_in       = rd_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      tok_head_in.valid  = req_accept && (req_data.action == ACT_OBSERVE);
      tok_head_in.placed = 1'b0;
      tok_head_in.sample = req_data.sample_value;

      // running totals advance as soon as the observe is taken
      if (tok_head_in.valid) begin
         count_in = count_ff + 32'd1;
         sum_in   = sum_ff + {32'd0, req_data.sample_value};
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.action == ACT_SNAPSHOT)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_SHIFT;
               rd_in    = '0;
            end
         end
         ST_SHIFT: begin
            if (rsp_load) begin
               rd_in = rd_ff + 3'd1;
               if (rsp_is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.bucket_id    = rd_ff;
         rsp_in.bucket_total = snap_link[0];
         rsp_in.samples_seen = count_ff;
         rsp_in.sample_total = sum_ff;
         rsp_in.last_bucket  = rsp_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rd_ff             <= '0;
         count_ff          <= '0;
         sum_ff            <= '0;
         tok_head_ff.valid <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         rd_ff             <= rd_in;
         count_ff          <= count_in;
         sum_ff            <= sum_in;
         tok_head_ff.valid <= tok_head_in.valid;
         rsp_valid_ff      <= rsp_valid_in;
      end
      tok_head_ff.placed <= tok_head_in.placed;
      tok_head_ff.sample <= tok_head_in.sample;
      rsp_ff             <= rsp_in;
   end

   assign chain_tok[0]     = tok_head_ff;
   assign snap_link[CELLS] = '0;

   // one cell per bucket; the final cell only ever serves as overflow
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [31:0]   bound;
      cell_ctrl_type ctrl;

      if (i < MAX_BOUNDS) begin : g_bound
         assign bound = bounds_ff[i];
      end else begin : g_no_bound
         assign bound = '0;
      end

      assign ctrl.active     = (3'(i) < n_used);
      assign ctrl.is_over    = (3'(i) == n_used);
      assign ctrl.snap_load  = snap_load;
      assign ctrl.snap_shift = rsp_load;

      bhc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .prev_tok       (chain_tok[i]),
         .bound          (bound),
         .ctrl           (ctrl),
         .snap_from_next (snap_link[i + 1]),
         .next_tok       (chain_tok[i + 1]),
         .snap_to_prev   (snap_link[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_snap_after_drain : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> !busy)
      else $error("sample still in the row during snapshot readout");

   a_rd_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (rd_ff <= n_used))
      else $error("readout index past overflow bucket");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_is_last) |=> (state_ff == ST_IDLE))
      else $error("snapshot did not end after its last response");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.action == ACT_OBSERVE))
         |=> (count_ff == $past(count_ff) + 32'd1))
      else $error("sample count did not advance on observe");
`endif

endmodule

`default_nettype wire
